FILE: hdl/rrc_pkg.sv
`default_nettype none
package rrc_pkg;

   localparam int MAX_ZONES_DEFAULT = 64;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_CHECK = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] CSR_FIRST_DATA_BLOCK   = 2'd0;
   localparam logic [1:0] CSR_TOTAL_BLOCKS       = 2'd1;
   localparam logic [1:0] CSR_ZONE_CHECK_ENABLED = 2'd2;

   typedef struct packed {
      logic [31:0] first_data_block;
      logic [63:0] total_blocks;
      logic        zone_check_enabled;
   } cfg_type;

   typedef struct packed {
      logic [63:0] start;
      logic [31:0] length;
   } zone_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CK_PRE,
      ST_CK_RD,
      ST_CK_EV,
      ST_AD_RD,
      ST_AD_EV,
      ST_SU_CK,
      ST_SU_RD,
      ST_SU_WR,
      ST_INS_WR,
      ST_PRED_CK,
      ST_PRED_RD,
      ST_PRED_EV,
      ST_RM_CK,
      ST_RM_RD,
      ST_RM_WR,
      ST_SUCC_CK,
      ST_SUCC_RD,
      ST_SUCC_EV,
      ST_DONE
   } state_type;

   function automatic logic [31:0] sat32(input logic [64:0] v);
      logic [31:0] r;
      r = (v[64:32] != 33'd0) ? 32'hFFFF_FFFF : v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/rrc_mem.sv
`default_nettype none
module rrc_mem
   import rrc_pkg::*;
#(
   parameter int DEPTH = MAX_ZONES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire zone_type      wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output zone_type           rd_data
);

   zone_type mem_ff [DEPTH];
   zone_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/rrc_csr.sv
`default_nettype none
module rrc_csr
   import rrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_data_block   <= 32'd0;
         cfg_ff.total_blocks       <= 64'd0;
         cfg_ff.zone_check_enabled <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_DATA_BLOCK:   cfg_ff.first_data_block   <= csr_wr_data[31:0];
            CSR_TOTAL_BLOCKS:       cfg_ff.total_blocks       <= csr_wr_data;
            CSR_ZONE_CHECK_ENABLED: cfg_ff.zone_check_enabled <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: hdl/reserved_block_range_checker.sv
`default_nettype none
// one item at a time; busy is high after the transfer through the result strobe
// check: limit test, then a scan of the stored zones if zone checking is on; clear: table emptied
// add: scan, then shift and insert if the range is new, then merges with both neighbours
// result on rsp_valid for one cycle; the receiver cannot stall
// synchronous reset empties the table, zeroes the error block, resets config
module reserved_block_range_checker
   import rrc_pkg::*;
#(
   parameter int MAX_ZONES = MAX_ZONES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [63:0] req_start_block,
   input  wire logic [31:0] req_block_count,
   output logic             rsp_valid,
   output logic             rsp_range_valid,
   output logic             rsp_status,
   output logic [63:0]      rsp_last_error_block,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wr_data
);

   localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int CW = $clog2(MAX_ZONES + 1);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] FULL = CW'(MAX_ZONES);

   cfg_type   cfg;
   state_type state_ff, state_in, ret_ff;

   logic [1:0]    kind_ff;
   logic [63:0]   start_ff, last_ff, cur_start_ff, err_ff;
   logic [31:0]   count_ff, cur_len_ff;
   logic [CW-1:0] idx_ff, ins_ff, p_ff, used_ff;
   logic          gt_seen_ff, range_ff, status_ff;

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   zone_type      mem_wr_data, rd;

   logic [CW-1:0] idx_inc, idx_dec, p_inc, p_dec;
   logic [64:0]   end_sum, need;
   logic [63:0]   diff_st, diff_cur;
   logic          limits_bad, overlap, contains, adj_pred, adj_succ;
   logic [31:0]   ext_len, pred_len, succ_len;

   rrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rrc_mem #(.DEPTH(MAX_ZONES), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd)
   );

   assign idx_inc = idx_ff + ONE;
   assign idx_dec = idx_ff - ONE;
   assign p_inc   = p_ff + ONE;
   assign p_dec   = p_ff - ONE;

   assign end_sum    = {1'b0, start_ff} + {33'd0, count_ff};
   assign limits_bad = (start_ff <= {32'd0, cfg.first_data_block}) || end_sum[64] ||
                       (end_sum[63:0] > cfg.total_blocks);

   assign diff_st  = start_ff - rd.start;
   assign diff_cur = cur_start_ff - rd.start;
   assign overlap  = (last_ff >= rd.start) &&
                     ((start_ff < rd.start) || (diff_st < {32'd0, rd.length}));
   assign contains = (start_ff >= rd.start) && (diff_st < {32'd0, rd.length});
   assign need     = {1'b0, diff_st} + {33'd0, count_ff};
   assign ext_len  = (need > {33'd0, rd.length}) ? sat32(need) : rd.length;

   assign adj_pred = (cur_start_ff >= rd.start) && (diff_cur == {32'd0, rd.length});
   assign adj_succ = (rd.start >= cur_start_ff) &&
                     ((rd.start - cur_start_ff) == {32'd0, cur_len_ff});
   assign pred_len = sat32({32'd0, {1'b0, cur_len_ff} + {1'b0, rd.length}});
   assign succ_len = pred_len;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_ADD:   state_in = (used_ff == '0) ? ST_INS_WR : ST_AD_RD;
                  KIND_CHECK: state_in = ST_CK_PRE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_CK_PRE: begin
            if (limits_bad || !cfg.zone_check_enabled || used_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_CK_RD;
            end
         end
         ST_CK_RD: state_in = ST_CK_EV;
         ST_CK_EV: begin
            if (overlap || idx_inc == used_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_CK_RD;
            end
         end
         ST_AD_RD: state_in = ST_AD_EV;
         ST_AD_EV: begin
            if (contains) begin
               state_in = ST_PRED_CK;
            end else if (idx_inc == used_ff) begin
               state_in = (used_ff == FULL) ? ST_DONE : ST_SU_CK;
            end else begin
               state_in = ST_AD_RD;
            end
         end
         ST_SU_CK:   state_in = (idx_ff > ins_ff) ? ST_SU_RD : ST_INS_WR;
         ST_SU_RD:   state_in = ST_SU_WR;
         ST_SU_WR:   state_in = ST_SU_CK;
         ST_INS_WR:  state_in = ST_PRED_CK;
         ST_PRED_CK: state_in = (p_ff != '0) ? ST_PRED_RD : ST_SUCC_CK;
         ST_PRED_RD: state_in = ST_PRED_EV;
         ST_PRED_EV: state_in = adj_pred ? ST_RM_CK : ST_SUCC_CK;
         ST_RM_CK:   state_in = (idx_inc < used_ff) ? ST_RM_RD : ret_ff;
         ST_RM_RD:   state_in = ST_RM_WR;
         ST_RM_WR:   state_in = ST_RM_CK;
         ST_SUCC_CK: state_in = (p_inc < used_ff) ? ST_SUCC_RD : ST_DONE;
         ST_SUCC_RD: state_in = ST_SUCC_EV;
         ST_SUCC_EV: state_in = adj_succ ? ST_RM_CK : ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory control and strobes
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = rd;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         ST_CK_RD, ST_AD_RD: begin
            mem_rd_en = 1'b1;
         end
         ST_AD_EV: begin
            mem_wr_en          = contains;
            mem_wr_data.start  = rd.start;
            mem_wr_data.length = ext_len;
         end
         ST_SU_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_dec[AW-1:0];
         end
         ST_SU_WR, ST_RM_WR: begin
            mem_wr_en = 1'b1;
         end
         ST_INS_WR: begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = ins_ff[AW-1:0];
            mem_wr_data.start  = start_ff;
            mem_wr_data.length = count_ff;
         end
         ST_PRED_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = p_dec[AW-1:0];
         end
         ST_PRED_EV: begin
            mem_wr_en          = adj_pred;
            mem_wr_addr        = p_dec[AW-1:0];
            mem_wr_data.start  = rd.start;
            mem_wr_data.length = pred_len;
         end
         ST_RM_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_inc[AW-1:0];
         end
         ST_SUCC_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = p_inc[AW-1:0];
         end
         ST_SUCC_EV: begin
            mem_wr_en          = adj_succ;
            mem_wr_addr        = p_ff[AW-1:0];
            mem_wr_data.start  = cur_start_ff;
            mem_wr_data.length = succ_len;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         err_ff   <= 64'd0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  kind_ff    <= req_kind;
                  start_ff   <= req_start_block;
                  count_ff   <= req_block_count;
                  idx_ff     <= '0;
                  ins_ff     <= '0;
                  p_ff       <= '0;
                  gt_seen_ff <= 1'b0;
                  range_ff   <= 1'b0;
                  status_ff  <= 1'b0;
                  if (req_kind == KIND_CLEAR) begin
                     used_ff <= '0;
                  end
               end
            end
            ST_CK_PRE: begin
               last_ff <= end_sum[63:0] - 64'd1;
               if (limits_bad) begin
                  err_ff <= start_ff;
               end else if (!cfg.zone_check_enabled || used_ff == '0) begin
                  range_ff <= 1'b1;
               end
            end
            ST_CK_EV: begin
               if (overlap) begin
                  err_ff <= start_ff;
               end else if (idx_inc == used_ff) begin
                  range_ff <= 1'b1;
               end else begin
                  idx_ff <= idx_inc;
               end
            end
            ST_AD_EV: begin
               if (contains) begin
                  cur_start_ff <= rd.start;
                  cur_len_ff   <= ext_len;
                  p_ff         <= idx_ff;
               end else begin
                  if (rd.start <= start_ff && !gt_seen_ff) begin
                     ins_ff <= idx_inc;
                  end else begin
                     gt_seen_ff <= 1'b1;
                  end
                  if (idx_inc == used_ff) begin
                     if (used_ff == FULL) begin
                        status_ff <= 1'b1;
                     end
                     idx_ff <= used_ff;
                  end else begin
                     idx_ff <= idx_inc;
                  end
               end
            end
            ST_SU_WR: idx_ff <= idx_dec;
            ST_INS_WR: begin
               cur_start_ff <= start_ff;
               cur_len_ff   <= count_ff;
               p_ff         <= ins_ff;
               used_ff      <= used_ff + ONE;
            end
            ST_PRED_EV: begin
               if (adj_pred) begin
                  cur_start_ff <= rd.start;
                  cur_len_ff   <= pred_len;
                  idx_ff       <= p_ff;
                  p_ff         <= p_dec;
                  ret_ff       <= ST_SUCC_CK;
               end
            end
            ST_RM_CK: begin
               if (!(idx_inc < used_ff)) begin
                  used_ff <= used_ff - ONE;
               end
            end
            ST_RM_WR: idx_ff <= idx_inc;
            ST_SUCC_EV: begin
               if (adj_succ) begin
                  cur_len_ff <= succ_len;
                  idx_ff     <= p_inc;
                  ret_ff     <= ST_DONE;
               end
            end
            default: ;
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_DONE);
   assign rsp_range_valid      = range_ff;
   assign rsp_status           = status_ff & (kind_ff == KIND_ADD);
   assign rsp_last_error_block = err_ff;

endmodule
`default_nettype wire

FILE: bench/tb_reserved_block_range_checker.sv
`timescale 1ns / 1ps
module tb_reserved_block_range_checker;
   import rrc_pkg::*;

   localparam int ZONE_CAP = 64;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        range_valid;
      logic        status;
      logic [63:0] last_error_block;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_CLEAR;
   logic [63:0] req_start_block = '0;
   logic [31:0] req_block_count = '0;
   logic        rsp_valid;
   logic        rsp_range_valid;
   logic        rsp_status;
   logic [63:0] rsp_last_error_block;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wr_data = '0;

   // model of the zone table
   logic [63:0] zt_start [ZONE_CAP];
   logic [31:0] zt_len [ZONE_CAP];
   int          zt_used;
   logic [63:0] err_block;
   logic [31:0] cfg_first;
   logic [63:0] cfg_total;
   logic        cfg_zone_en;

   verdict_type pending_verdicts [$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int adds_full = 0;
   int checks_valid = 0;
   int idle_cycles = 0;

   reserved_block_range_checker uut (.*);

   always #10 clock = ~clock;

   function automatic logic [31:0] clamp32(input logic [64:0] v);
      return (v[64:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic bit zone_abuts(input int a, input int b);
      return zt_start[b] >= zt_start[a] &&
         (zt_start[b] - zt_start[a]) == {32'd0, zt_len[a]};
   endfunction

   function automatic void drop_zone(input int idx);
      for (int i = idx; i + 1 < zt_used; i++) begin
         zt_start[i] = zt_start[i+1];
         zt_len[i] = zt_len[i+1];
      end
      zt_used--;
   endfunction

   function automatic bit reserve_zone(input logic [63:0] s, input logic [31:0] c);
      int  p;
      bit  hit;
      logic [64:0] need;
      p = zt_used;
      hit = 0;
      for (int i = 0; i < zt_used; i++) begin
         if (s >= zt_start[i] && (s - zt_start[i]) < {32'd0, zt_len[i]}) begin
            need = {1'b0, s - zt_start[i]} + {33'd0, c};
            if (need > {33'd0, zt_len[i]}) zt_len[i] = clamp32(need);
            p = i;
            hit = 1;
            break;
         end
      end
      if (!hit) begin
         if (zt_used >= ZONE_CAP) return 1;
         p = 0;
         while (p < zt_used && zt_start[p] <= s) p++;
         for (int i = zt_used; i > p; i--) begin
            zt_start[i] = zt_start[i-1];
            zt_len[i] = zt_len[i-1];
         end
         zt_start[p] = s;
         zt_len[p] = c;
         zt_used++;
      end
      if (p > 0 && zone_abuts(p - 1, p)) begin
         zt_start[p] = zt_start[p-1];
         zt_len[p] = clamp32({33'd0, zt_len[p]} + {33'd0, zt_len[p-1]});
         drop_zone(p - 1);
         p--;
      end
      if (p + 1 < zt_used && zone_abuts(p, p + 1)) begin
         zt_len[p] = clamp32({33'd0, zt_len[p]} + {33'd0, zt_len[p+1]});
         drop_zone(p + 1);
      end
      return 0;
   endfunction

   function automatic bit range_usable(input logic [63:0] s, input logic [31:0] c);
      logic [64:0] fin;
      logic [63:0] last;
      fin = {1'b0, s} + {33'd0, c};
      if (s <= {32'd0, cfg_first} || fin[64] || fin[63:0] > cfg_total) begin
         err_block = s;
         return 0;
      end
      if (!cfg_zone_en) return 1;
      last = fin[63:0] - 64'd1;
      for (int i = 0; i < zt_used; i++) begin
         if (last >= zt_start[i] &&
            (s < zt_start[i] || (s - zt_start[i]) < {32'd0, zt_len[i]})) begin
            err_block = s;
            return 0;
         end
      end
      return 1;
   endfunction

   function automatic verdict_type predict_verdict(input logic [1:0] k,
      input logic [63:0] s, input logic [31:0] c);
      verdict_type v;
      v = '0;
      case (k)
         KIND_ADD: v.status = reserve_zone(s, c);
         KIND_CHECK: v.range_valid = range_usable(s, c);
         KIND_CLEAR: zt_used = 0;
         default: ;
      endcase
      v.last_error_block = err_block;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // result checker
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected transfer", '0, '0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_range_valid !== want.range_valid)
               report_mismatch("range_valid", {63'd0, rsp_range_valid},
                  {63'd0, want.range_valid});
            if (rsp_status !== want.status)
               report_mismatch("status", {63'd0, rsp_status}, {63'd0, want.status});
            if (rsp_last_error_block !== want.last_error_block)
               report_mismatch("last_error_block", rsp_last_error_block,
                  want.last_error_block);
            if (want.status) adds_full++;
            if (want.range_valid) checks_valid++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   // start stays high after a transfer until the next gap or settle
   task automatic send_item(input logic [1:0] k, input logic [63:0] s,
      input logic [31:0] c);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= k;
      req_start_block <= s;
      req_block_count <= c;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_verdicts.push_back(predict_verdict(k, s, c));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle;
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FIRST_DATA_BLOCK: cfg_first = val[31:0];
         CSR_TOTAL_BLOCKS: cfg_total = val;
         CSR_ZONE_CHECK_ENABLED: cfg_zone_en = val[0];
         default: ;
      endcase
   endtask

   task automatic set_volume(input logic [31:0] f, input logic [63:0] t, input logic en);
      settle();
      write_csr(CSR_FIRST_DATA_BLOCK, {$urandom, f});
      write_csr(CSR_TOTAL_BLOCKS, t);
      write_csr(CSR_ZONE_CHECK_ENABLED, {63'h0, en});
      write_csr(2'd3, {$urandom, $urandom});
   endtask

   task automatic test_directed;
      set_volume(32'd100, 64'd100000, 1'b1);
      send_item(KIND_CHECK, 64'd100, 32'd1);
      send_item(KIND_CHECK, 64'd101, 32'd10);
      send_item(KIND_CHECK, 64'd99990, 32'd10);
      send_item(KIND_CHECK, 64'd99991, 32'd10);
      send_item(KIND_CHECK, '1, '1);
      send_item(KIND_ADD, 64'd1000, 32'd100);
      send_item(KIND_ADD, 64'd1100, 32'd50);
      send_item(KIND_ADD, 64'd900, 32'd100);
      send_item(KIND_ADD, 64'd950, 32'd400);
      send_item(KIND_ADD, 64'd2000, 32'd0);
      send_item(KIND_ADD, 64'd2000, 32'd5);
      send_item(KIND_CHECK, 64'd1349, 32'd1);
      send_item(KIND_CHECK, 64'd1350, 32'd0);
      send_item(KIND_CHECK, 64'd1351, 32'd0);
      send_item(KIND_CHECK, 64'd800, 32'd100);
      send_item(KIND_CHECK, 64'd800, 32'd101);
      send_item(KIND_ADD, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF);
      send_item(KIND_ADD, 64'hFFFF_FFFF_0000_0001, 32'hFFFF_FFFF);
      send_item(KIND_ADD, 64'hFFFF_FFFE_0000_0001, 32'hFFFF_FFFF);
      send_item(2'd3, '1, '1);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_CHECK, 64'd1000, 32'd10);
   endtask

   task automatic test_table_full;
      for (int i = 0; i < ZONE_CAP + 3; i++)
         send_item(KIND_ADD, 64'd500 + 64'(i) * 20, 32'd5 + 32'(i % 3));
      send_item(KIND_ADD, 64'd502, 32'd30);
      send_item(KIND_CHECK, 64'd506, 32'd2);
      send_item(KIND_CHECK, 64'd530, 32'd0);
      send_item(KIND_CLEAR, 0, 0);
   endtask

   task automatic random_phase(input int n, input logic [63:0] span);
      logic [63:0] s;
      logic [31:0] c;
      logic [1:0] k;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) k = KIND_ADD;
         else if (r < 93) k = KIND_CHECK;
         else if (r < 96) k = KIND_CLEAR;
         else k = 2'd3;
         if ($urandom_range(0, 19) == 0) begin
            s = {$urandom, $urandom};
            c = $urandom;
         end else begin
            s = 64'($urandom_range(0, 32'(span)));
            c = $urandom_range(0, 40);
            if (zt_used > 0 && $urandom_range(0, 2) == 0) begin
               r = $urandom_range(0, zt_used - 1);
               s = zt_start[r] + (($urandom_range(0, 1)) ? 64'(zt_len[r]) : 64'd0)
                  - 64'($urandom_range(0, 1));
            end
         end
         send_item(k, s, c);
      end
   endtask

   task automatic test_random;
      set_volume(32'd10, 64'd4000, 1'b1);
      random_phase(300, 64'd4000);
      set_volume(32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      random_phase(150, 64'd3000);
      set_volume(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      random_phase(100, 64'h1_0000_0800);
      set_volume(32'd3, 64'd0, 1'b1);
      random_phase(50, 64'd100);
      set_volume(32'd50, 64'd1500, 1'b1);
      random_phase(350, 64'd1500);
   endtask

   initial begin
      cfg_first = 0;
      cfg_total = 0;
      cfg_zone_en = 1;
      zt_used = 0;
      err_block = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random();
      settle();
      $display("%0d items sent, %0d results checked", items_sent, results_seen);
      $display("%0d valid checks, %0d adds refused as full", checks_valid, adds_full);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
